// ===== rtl/core/cil_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contact impulse package
// Shared widths, the side-band record carried down the pipeline and the
// signed 32-bit saturation used by the front and back ends.
// ----------------------------------------------------------------------------
package cil_pkg;

   localparam int DATA_W     = 32;
   localparam int PROPS_W    = 26;
   localparam int IM_W       = 16;
   localparam int E_W        = 9;
   localparam int E_LSB      = 16;
   localparam int STATIC_BIT = 25;
   localparam int IM_FRAC    = 8;
   localparam int ONE_E      = 256;
   localparam int VNS_W      = 31;
   localparam int NUM_W      = 41;
   localparam int DEN_W      = 17;
   localparam int VN_W       = 67;
   localparam int WIDE_W     = 72;
   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;

   localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(2147483647);
   localparam logic signed [WIDE_W-1:0] SAT_MIN = -SAT_MAX - WIDE_W'(1);
   localparam logic signed [VN_W-1:0]   VNS_MAX = VN_W'(2147483647);
   localparam logic [NUM_W-1:0]         Q_LIM   = NUM_W'(64'd2147483648);

   // Index 0 is x, 1 is y, 2 is z.
   typedef logic [2:0][DATA_W-1:0] vec_type;

   typedef struct packed {
      vec_type         n;
      vec_type         va;
      vec_type         vb;
      vec_type         ca;
      vec_type         cb;
      logic [IM_W-1:0] ima;
      logic [IM_W-1:0] imb;
      logic            dyn_a;
      logic            dyn_b;
      logic            apply;
   } side_type;

   function automatic logic [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] r;
      r = x;
      if (x > SAT_MAX) begin
         r = SAT_MAX;
      end else if (x < SAT_MIN) begin
         r = SAT_MIN;
      end
      return r[DATA_W-1:0];
   endfunction

endpackage

// ===== rtl/core/cil_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Contact impulse front end
// Four stages: input register, normal products, corrections and normal
// velocity, then the scaled dividend and the inverse-mass sum.
// ----------------------------------------------------------------------------
module cil_front #(
   parameter int FRAC_BITS = 16
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           in_valid,
   output logic                          in_ready,
   input  wire cil_pkg::vec_type         in_n,
   input  wire [cil_pkg::DATA_W-1:0]     in_d,
   input  wire cil_pkg::vec_type         in_va,
   input  wire cil_pkg::vec_type         in_vb,
   input  wire [cil_pkg::PROPS_W-1:0]    in_props_a,
   input  wire [cil_pkg::PROPS_W-1:0]    in_props_b,
   output logic                          out_valid,
   input  wire                           out_ready,
   output logic [cil_pkg::NUM_W-1:0]     out_num,
   output logic [cil_pkg::DEN_W-1:0]     out_den,
   output cil_pkg::side_type             out_side
);

   // Stage A: inputs.
   logic                         a_vld_ff;
   cil_pkg::vec_type             a_n_ff, a_va_ff, a_vb_ff;
   logic [cil_pkg::DATA_W-1:0]   a_d_ff;
   logic [cil_pkg::PROPS_W-1:0]  a_pa_ff, a_pb_ff;

   // Stage B: products.
   logic                         b_vld_ff;
   logic signed [63:0]           b_p_ff [3];
   logic signed [63:0]           b_p_in [3];
   logic signed [64:0]           b_r_ff [3];
   logic signed [64:0]           b_r_in [3];
   logic signed [32:0]           b_dv   [3];
   cil_pkg::vec_type             b_n_ff, b_va_ff, b_vb_ff;
   logic [cil_pkg::PROPS_W-1:0]  b_pa_ff, b_pb_ff;

   // Stage C: corrections and normal velocity.
   logic                         c_vld_ff;
   logic signed [63:0]           c_full_sh [3];
   logic signed [63:0]           c_half_sh [3];
   logic signed [64:0]           c_rs      [3];
   logic [cil_pkg::DATA_W-1:0]   c_full    [3];
   logic [cil_pkg::DATA_W-1:0]   c_half    [3];
   cil_pkg::side_type            c_side_ff, c_side_in;
   logic signed [cil_pkg::VN_W-1:0] c_vn_ff, c_vn_in;
   logic [cil_pkg::E_W-1:0]      c_e_ff, c_e_in, c_ea, c_eb;

   // Stage D: dividend and divisor.
   logic                         d_vld_ff;
   logic [cil_pkg::NUM_W-1:0]    d_num_ff, d_num_in;
   logic [cil_pkg::DEN_W-1:0]    d_den_ff, d_den_in;
   cil_pkg::side_type            d_side_ff, d_side_in;
   logic [cil_pkg::VNS_W-1:0]    d_vns;
   logic [cil_pkg::E_W:0]        d_scale;

   logic en_a, en_b, en_c, en_d;

   assign en_d     = !d_vld_ff || out_ready;
   assign en_c     = !c_vld_ff || en_d;
   assign en_b     = !b_vld_ff || en_c;
   assign en_a     = !a_vld_ff || en_b;
   assign in_ready = en_a;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_p_in[i] = $signed(a_n_ff[i]) * $signed(a_d_ff);
         b_dv[i]   = $signed({a_vb_ff[i][cil_pkg::DATA_W-1], a_vb_ff[i]})
                   - $signed({a_va_ff[i][cil_pkg::DATA_W-1], a_va_ff[i]});
         b_r_in[i] = b_dv[i] * $signed(a_n_ff[i]);
      end
   end

   always_comb begin
      c_side_in       = '0;
      c_side_in.n     = b_n_ff;
      c_side_in.va    = b_va_ff;
      c_side_in.vb    = b_vb_ff;
      c_side_in.ima   = b_pa_ff[cil_pkg::IM_W-1:0];
      c_side_in.imb   = b_pb_ff[cil_pkg::IM_W-1:0];
      c_side_in.dyn_a = !b_pa_ff[cil_pkg::STATIC_BIT];
      c_side_in.dyn_b = !b_pb_ff[cil_pkg::STATIC_BIT];
      for (int i = 0; i < 3; i++) begin
         c_full_sh[i] = b_p_ff[i] >>> FRAC_BITS;
         c_half_sh[i] = b_p_ff[i] >>> (FRAC_BITS + 1);
         c_rs[i]      = b_r_ff[i] >>> FRAC_BITS;
         c_full[i]    = cil_pkg::sat32(cil_pkg::WIDE_W'(c_full_sh[i]));
         c_half[i]    = cil_pkg::sat32(cil_pkg::WIDE_W'(c_half_sh[i]));
         if (c_side_in.dyn_a && c_side_in.dyn_b) begin
            c_side_in.ca[i] = c_half[i];
            c_side_in.cb[i] = cil_pkg::sat32(-cil_pkg::WIDE_W'($signed(c_half[i])));
         end else if (c_side_in.dyn_a) begin
            c_side_in.ca[i] = c_full[i];
            c_side_in.cb[i] = '0;
         end else if (c_side_in.dyn_b) begin
            c_side_in.ca[i] = '0;
            c_side_in.cb[i] = cil_pkg::sat32(-cil_pkg::WIDE_W'($signed(c_full[i])));
         end else begin
            c_side_in.ca[i] = '0;
            c_side_in.cb[i] = '0;
         end
      end
      c_vn_in = cil_pkg::VN_W'(c_rs[0]) + cil_pkg::VN_W'(c_rs[1])
              + cil_pkg::VN_W'(c_rs[2]);
      c_ea    = b_pa_ff[cil_pkg::E_LSB +: cil_pkg::E_W];
      c_eb    = b_pb_ff[cil_pkg::E_LSB +: cil_pkg::E_W];
      c_e_in  = (c_ea < c_eb) ? c_ea : c_eb;
   end

   always_comb begin
      d_vns = (c_vn_ff > cil_pkg::VNS_MAX) ? '1 : c_vn_ff[cil_pkg::VNS_W-1:0];
      d_scale  = (cil_pkg::E_W+1)'(cil_pkg::ONE_E) + (cil_pkg::E_W+1)'(c_e_ff);
      d_num_in = cil_pkg::NUM_W'(d_scale) * cil_pkg::NUM_W'(d_vns);
      d_den_in = cil_pkg::DEN_W'(c_side_ff.ima) + cil_pkg::DEN_W'(c_side_ff.imb);
      d_side_in       = c_side_ff;
      // A separating contact has a negative normal velocity; only then is there
      // no impulse, and likewise when neither body has inverse mass.
      d_side_in.apply = !c_vn_ff[cil_pkg::VN_W-1] && (d_den_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         if (en_a) a_vld_ff <= in_valid;
         if (en_b) b_vld_ff <= a_vld_ff;
         if (en_c) c_vld_ff <= b_vld_ff;
         if (en_d) d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_n_ff  <= in_n;
         a_d_ff  <= in_d;
         a_va_ff <= in_va;
         a_vb_ff <= in_vb;
         a_pa_ff <= in_props_a;
         a_pb_ff <= in_props_b;
      end
      if (en_b) begin
         b_p_ff  <= b_p_in;
         b_r_ff  <= b_r_in;
         b_n_ff  <= a_n_ff;
         b_va_ff <= a_va_ff;
         b_vb_ff <= a_vb_ff;
         b_pa_ff <= a_pa_ff;
         b_pb_ff <= a_pb_ff;
      end
      if (en_c) begin
         c_side_ff <= c_side_in;
         c_vn_ff   <= c_vn_in;
         c_e_ff    <= c_e_in;
      end
      if (en_d) begin
         d_num_ff  <= d_num_in;
         d_den_ff  <= d_den_in;
         d_side_ff <= d_side_in;
      end
   end

   assign out_valid = d_vld_ff;
   assign out_num   = d_num_ff;
   assign out_den   = d_den_ff;
   assign out_side  = d_side_ff;

endmodule
`default_nettype wire

// ===== rtl/core/cil_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Contact impulse divider
// Pipelined restoring division, four quotient bits per stage and one in the
// last, with the contact side-band traveling beside the partial remainder.
// ----------------------------------------------------------------------------
module cil_div (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_valid,
   output logic                       in_ready,
   input  wire [cil_pkg::NUM_W-1:0]   in_num,
   input  wire [cil_pkg::DEN_W-1:0]   in_den,
   input  wire cil_pkg::side_type     in_side,
   output logic                       out_valid,
   input  wire                        out_ready,
   output logic [cil_pkg::NUM_W-1:0]  out_quo,
   output cil_pkg::side_type          out_side
);

   localparam int NS = cil_pkg::DIV_STAGES;

   logic                        vld_ff   [NS];
   logic                        en       [NS];
   logic [cil_pkg::DEN_W-1:0]   rem_ff   [NS];
   logic [cil_pkg::DEN_W-1:0]   rem_in   [NS];
   logic [cil_pkg::NUM_W-1:0]   nq_ff    [NS];
   logic [cil_pkg::NUM_W-1:0]   nq_in    [NS];
   logic [cil_pkg::DEN_W-1:0]   den_ff   [NS];
   cil_pkg::side_type           side_ff  [NS];

   // What each stage loads from: the module inputs for the first stage and
   // the stage before it for the rest.
   logic                        vld_src  [NS];
   logic [cil_pkg::DEN_W-1:0]   rem_src  [NS];
   logic [cil_pkg::NUM_W-1:0]   nq_src   [NS];
   logic [cil_pkg::DEN_W-1:0]   den_src  [NS];
   cil_pkg::side_type           side_src [NS];

   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || out_ready;
      for (int s = NS - 2; s >= 0; s--) begin
         en[s] = !vld_ff[s] || en[s+1];
      end
   end

   assign in_ready = en[0];

   always_comb begin
      vld_src[0]  = in_valid;
      rem_src[0]  = '0;
      nq_src[0]   = in_num;
      den_src[0]  = in_den;
      side_src[0] = in_side;
      for (int s = 1; s < NS; s++) begin
         vld_src[s]  = vld_ff[s-1];
         rem_src[s]  = rem_ff[s-1];
         nq_src[s]   = nq_ff[s-1];
         den_src[s]  = den_ff[s-1];
         side_src[s] = side_ff[s-1];
      end
   end

   // The numerator shifts out of the top of nq while quotient bits shift in
   // at the bottom; after the last step nq holds the quotient.
   always_comb begin
      logic [cil_pkg::DEN_W:0]   t;
      logic [cil_pkg::DEN_W-1:0] r;
      logic [cil_pkg::NUM_W-1:0] q;
      logic [cil_pkg::DEN_W-1:0] dv;
      for (int s = 0; s < NS; s++) begin
         r  = rem_src[s];
         q  = nq_src[s];
         dv = den_src[s];
         for (int k = 0; k < cil_pkg::DIV_STEP; k++) begin
            if (s * cil_pkg::DIV_STEP + k < cil_pkg::NUM_W) begin
               t = {r, q[cil_pkg::NUM_W-1]};
               if (t >= {1'b0, dv}) begin
                  r = cil_pkg::DEN_W'(t - {1'b0, dv});
                  q = {q[cil_pkg::NUM_W-2:0], 1'b1};
               end else begin
                  r = t[cil_pkg::DEN_W-1:0];
                  q = {q[cil_pkg::NUM_W-2:0], 1'b0};
               end
            end
         end
         rem_in[s] = r;
         nq_in[s]  = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
               vld_ff[s] <= vld_src[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NS; s++) begin
         if (en[s]) begin
            rem_ff[s]  <= rem_in[s];
            nq_ff[s]   <= nq_in[s];
            den_ff[s]  <= den_src[s];
            side_ff[s] <= side_src[s];
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_quo   = nq_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule
`default_nettype wire

// ===== rtl/core/cil_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Contact impulse back end
// Five stages: impulse magnitude, impulse along the normal, saturation,
// inverse-mass scaling and the saturated velocity update (output register).
// ----------------------------------------------------------------------------
module cil_back #(
   parameter int FRAC_BITS = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_valid,
   output logic                       in_ready,
   input  wire [cil_pkg::NUM_W-1:0]   in_quo,
   input  wire cil_pkg::side_type     in_side,
   output logic                       out_valid,
   input  wire                        out_ready,
   output cil_pkg::vec_type           out_ca,
   output cil_pkg::vec_type           out_cb,
   output cil_pkg::vec_type           out_nva,
   output cil_pkg::vec_type           out_nvb
);

   logic                        j_vld_ff, p_vld_ff, i_vld_ff, m_vld_ff, o_vld_ff;
   logic                        en_j, en_p, en_i, en_m, en_o;

   logic [cil_pkg::DATA_W-1:0]  j_qs;
   logic signed [cil_pkg::DATA_W:0] j_ff, j_in;
   cil_pkg::side_type           j_side_ff, p_side_ff, i_side_ff, m_side_ff, o_side_ff;

   logic signed [64:0]          p_ff [3];
   logic signed [64:0]          p_in [3];
   logic signed [64:0]          i_sh [3];
   logic [cil_pkg::DATA_W-1:0]  i_ff [3];
   logic [cil_pkg::DATA_W-1:0]  i_in [3];
   logic signed [48:0]          ma_ff [3];
   logic signed [48:0]          ma_in [3];
   logic signed [48:0]          mb_ff [3];
   logic signed [48:0]          mb_in [3];
   logic signed [48:0]          o_sha [3];
   logic signed [48:0]          o_shb [3];
   cil_pkg::vec_type            o_nva_ff, o_nva_in, o_nvb_ff, o_nvb_in;

   assign en_o     = !o_vld_ff || out_ready;
   assign en_m     = !m_vld_ff || en_o;
   assign en_i     = !i_vld_ff || en_m;
   assign en_p     = !p_vld_ff || en_i;
   assign en_j     = !j_vld_ff || en_p;
   assign in_ready = en_j;

   // The quotient is clipped at 2^31 so that j = -q fits in 32 bits.
   always_comb begin
      j_qs = (in_quo > cil_pkg::Q_LIM) ? cil_pkg::Q_LIM[cil_pkg::DATA_W-1:0]
                                       : in_quo[cil_pkg::DATA_W-1:0];
      j_in = -$signed({1'b0, j_qs});
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_in[i]  = j_ff * $signed(j_side_ff.n[i]);
         i_sh[i]  = p_ff[i] >>> FRAC_BITS;
         i_in[i]  = cil_pkg::sat32(cil_pkg::WIDE_W'(i_sh[i]));
         ma_in[i] = $signed(i_ff[i]) * $signed({1'b0, i_side_ff.ima});
         mb_in[i] = $signed(i_ff[i]) * $signed({1'b0, i_side_ff.imb});
         o_sha[i] = ma_ff[i] >>> cil_pkg::IM_FRAC;
         o_shb[i] = mb_ff[i] >>> cil_pkg::IM_FRAC;
         o_nva_in[i] = m_side_ff.va[i];
         o_nvb_in[i] = m_side_ff.vb[i];
         if (m_side_ff.apply && m_side_ff.dyn_a) begin
            o_nva_in[i] = cil_pkg::sat32(cil_pkg::WIDE_W'($signed(m_side_ff.va[i]))
                                       - cil_pkg::WIDE_W'(o_sha[i]));
         end
         if (m_side_ff.apply && m_side_ff.dyn_b) begin
            o_nvb_in[i] = cil_pkg::sat32(cil_pkg::WIDE_W'($signed(m_side_ff.vb[i]))
                                       + cil_pkg::WIDE_W'(o_shb[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_vld_ff <= 1'b0;
         p_vld_ff <= 1'b0;
         i_vld_ff <= 1'b0;
         m_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         if (en_j) j_vld_ff <= in_valid;
         if (en_p) p_vld_ff <= j_vld_ff;
         if (en_i) i_vld_ff <= p_vld_ff;
         if (en_m) m_vld_ff <= i_vld_ff;
         if (en_o) o_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_j) begin
         j_ff      <= j_in;
         j_side_ff <= in_side;
      end
      if (en_p) begin
         p_ff      <= p_in;
         p_side_ff <= j_side_ff;
      end
      if (en_i) begin
         i_ff      <= i_in;
         i_side_ff <= p_side_ff;
      end
      if (en_m) begin
         ma_ff     <= ma_in;
         mb_ff     <= mb_in;
         m_side_ff <= i_side_ff;
      end
      if (en_o) begin
         o_nva_ff  <= o_nva_in;
         o_nvb_ff  <= o_nvb_in;
         o_side_ff <= m_side_ff;
      end
   end

   assign out_valid = o_vld_ff;
   assign out_ca    = o_side_ff.ca;
   assign out_cb    = o_side_ff.cb;
   assign out_nva   = o_nva_ff;
   assign out_nvb   = o_nvb_ff;

endmodule
`default_nettype wire

// ===== rtl/core/contact_impulse_linear_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear contact impulse response
// Position corrections and post-impulse velocities for one contact.
// ----------------------------------------------------------------------------
// Usage:
// One contact enters on the req_ channel (valid/ready) and one result leaves
// on the rsp_ channel (valid/ready); a transaction takes place on a clock
// edge where valid and ready are both high.
// The pipeline is 20 register stages deep: 4 front-end stages (input
// register, products, corrections with normal velocity, dividend), 11
// divider stages of four quotient bits each (one in the last), and 5
// back-end stages ending in the output register.
// When the output side is not stalled, one contact is taken every cycle.
// Each stage holds while the stage after it is full and stalled, and an
// empty stage fills regardless, so bubbles close up; req_ready drops only
// once every stage holds a contact. Nothing is lost or repeated.
// Synchronous reset empties all stages; no contact is pending afterward.
// There is no configuration.
// ----------------------------------------------------------------------------
module contact_impulse_linear_top #(
   parameter int FRAC_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire [31:0]  req_normal_x,
   input  wire [31:0]  req_normal_y,
   input  wire [31:0]  req_normal_z,
   input  wire [31:0]  req_depth,
   input  wire [31:0]  req_vel_a_x,
   input  wire [31:0]  req_vel_a_y,
   input  wire [31:0]  req_vel_a_z,
   input  wire [31:0]  req_vel_b_x,
   input  wire [31:0]  req_vel_b_y,
   input  wire [31:0]  req_vel_b_z,
   input  wire [25:0]  req_props_a,
   input  wire [25:0]  req_props_b,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_corr_a_x,
   output logic [31:0] rsp_corr_a_y,
   output logic [31:0] rsp_corr_a_z,
   output logic [31:0] rsp_corr_b_x,
   output logic [31:0] rsp_corr_b_y,
   output logic [31:0] rsp_corr_b_z,
   output logic [31:0] rsp_new_vel_a_x,
   output logic [31:0] rsp_new_vel_a_y,
   output logic [31:0] rsp_new_vel_a_z,
   output logic [31:0] rsp_new_vel_b_x,
   output logic [31:0] rsp_new_vel_b_y,
   output logic [31:0] rsp_new_vel_b_z
);

   cil_pkg::vec_type            req_n, req_va, req_vb;
   cil_pkg::vec_type            out_ca, out_cb, out_nva, out_nvb;

   logic                        fd_valid, fd_ready;
   logic [cil_pkg::NUM_W-1:0]   fd_num;
   logic [cil_pkg::DEN_W-1:0]   fd_den;
   cil_pkg::side_type           fd_side;

   logic                        db_valid, db_ready;
   logic [cil_pkg::NUM_W-1:0]   db_quo;
   cil_pkg::side_type           db_side;

   assign req_n  = {req_normal_z, req_normal_y, req_normal_x};
   assign req_va = {req_vel_a_z, req_vel_a_y, req_vel_a_x};
   assign req_vb = {req_vel_b_z, req_vel_b_y, req_vel_b_x};

   cil_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_n       (req_n),
      .in_d       (req_depth),
      .in_va      (req_va),
      .in_vb      (req_vb),
      .in_props_a (req_props_a),
      .in_props_b (req_props_b),
      .out_valid  (fd_valid),
      .out_ready  (fd_ready),
      .out_num    (fd_num),
      .out_den    (fd_den),
      .out_side   (fd_side)
   );

   cil_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fd_valid),
      .in_ready  (fd_ready),
      .in_num    (fd_num),
      .in_den    (fd_den),
      .in_side   (fd_side),
      .out_valid (db_valid),
      .out_ready (db_ready),
      .out_quo   (db_quo),
      .out_side  (db_side)
   );

   cil_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (db_valid),
      .in_ready  (db_ready),
      .in_quo    (db_quo),
      .in_side   (db_side),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_ca    (out_ca),
      .out_cb    (out_cb),
      .out_nva   (out_nva),
      .out_nvb   (out_nvb)
   );

   assign rsp_corr_a_x    = out_ca[0];
   assign rsp_corr_a_y    = out_ca[1];
   assign rsp_corr_a_z    = out_ca[2];
   assign rsp_corr_b_x    = out_cb[0];
   assign rsp_corr_b_y    = out_cb[1];
   assign rsp_corr_b_z    = out_cb[2];
   assign rsp_new_vel_a_x = out_nva[0];
   assign rsp_new_vel_a_y = out_nva[1];
   assign rsp_new_vel_a_z = out_nva[2];
   assign rsp_new_vel_b_x = out_nvb[0];
   assign rsp_new_vel_b_y = out_nvb[1];
   assign rsp_new_vel_b_z = out_nvb[2];

endmodule
`default_nettype wire
